FILE: hw/rtl/pnm_pkg.sv
`default_nettype none
package pnm_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_file;
  } pnm_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [1:0]  error_code;
    logic        last_pixel;
    logic        last_in_run;
  } pnm_out_t;

  // Result kinds
  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_MAGIC  = 2'd0;
  localparam logic [1:0] ERR_EOF    = 2'd1;
  localparam logic [1:0] ERR_MAXVAL = 2'd2;

  // Command codes from front to back
  typedef enum logic [1:0] {
    OP_EMIT   = 2'd0,  // emit res as is
    OP_SAMPLE = 2'd1,  // scale value, then gray or RGB
    OP_BITS   = 2'd2   // unpack binary PBM byte
  } pnm_op_e;

  typedef struct packed {
    pnm_op_e     op;
    logic [15:0] value;
    logic [3:0]  bit_cnt;   // pixels in a BITS op
    logic        done_run;  // image completes inside this op
    pnm_out_t    res;
  } pnm_cmd_t;

  typedef enum logic [2:0] {
    PH_MAGIC  = 3'd0,
    PH_FORMAT = 3'd1,
    PH_WIDTH  = 3'd2,
    PH_HEIGHT = 3'd3,
    PH_MAXVAL = 3'd4,
    PH_PIXELS = 3'd5,
    PH_DONE   = 3'd6
  } pnm_phase_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_OUT  = 2'd2,
    BK_BITS = 2'd3
  } pnm_back_e;

endpackage
`default_nettype wire

FILE: hw/rtl/pnm_front.sv
`default_nettype none
module pnm_front #(
  parameter int DimBits = 16
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_stall_o,
  input  pnm_pkg::pnm_in_t in_data_i,
  output logic            cmd_valid_o,
  input  wire             cmd_full_i,
  output pnm_pkg::pnm_cmd_t cmd_o,
  output logic [15:0]     maxval_o,
  output logic [2:0]      format_o
);
  import pnm_pkg::*;

  localparam logic [16:0] DimMax = 17'((1 << DimBits) - 1);

  pnm_phase_e  phase_q, phase_d;
  logic [2:0]  fmt_q, fmt_d;
  logic [15:0] wid_q, wid_d, hgt_q, hgt_d, max_q, max_d, acc_q, acc_d;
  logic        cmt_q, cmt_d, dig_q, dig_d;
  logic [31:0] left_q, left_d;
  logic [15:0] col_q, col_d;
  logic [1:0]  comp_q, comp_d;
  // pixel product is computed in the cycle after the height token ends
  logic        mul_q, mul_d;

  logic        take;
  logic [7:0]  c;
  logic        is_dig, is_sp, tok;
  logic [15:0] tokv;
  logic [19:0] acc10;
  logic [15:0] cnt;
  logic [3:0]  nbits;

  assign in_stall_o = cmd_full_i || mul_q;
  assign take = in_valid_i && !in_stall_o;
  assign c = in_data_i.in_byte;
  assign maxval_o = max_q;
  assign format_o = fmt_q;

  // token parser
  always_comb begin
    is_dig = (c >= 8'h30) && (c <= 8'h39);
    is_sp = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
    acc10 = {4'd0, acc_q} * 20'd10 + {16'd0, c[3:0]};
    tok = 1'b0;
    tokv = acc_q;
    cmt_d = cmt_q;
    dig_d = dig_q;
    acc_d = acc_q;
    if (cmt_q) begin
      if (c == 8'h0a) cmt_d = 1'b0;
    end else if (dig_q) begin
      if (is_dig) begin
        acc_d = (acc10 > 20'd65535) ? 16'hffff : acc10[15:0];
      end else begin
        dig_d = 1'b0;
        tok = 1'b1;
      end
    end else if (c == 8'h23) begin
      cmt_d = 1'b1;
    end else if (is_sp) begin
      tok = 1'b0;
    end else if (is_dig) begin
      dig_d = 1'b1;
      acc_d = {12'd0, c[3:0]};
    end else begin
      acc_d = 16'd0;
      tokv = 16'd0;
      tok = 1'b1;
    end
  end

  always_comb begin
    cnt = wid_q - col_q;
    nbits = (cnt > 16'd8) ? 4'd8 : cnt[3:0];
  end

  // phase control and command issue
  always_comb begin
    phase_d = phase_q;
    fmt_d = fmt_q;
    wid_d = wid_q;
    hgt_d = hgt_q;
    max_d = max_q;
    left_d = left_q;
    col_d = col_q;
    comp_d = comp_q;
    mul_d = 1'b0;
    cmd_valid_o = 1'b0;
    cmd_o = '0;
    cmd_o.op = OP_EMIT;
    cmd_o.res.last_in_run = 1'b1;
    if (mul_q) begin
      left_d = {16'd0, wid_q} * {16'd0, hgt_q};
      if (fmt_q == 3'd1 || fmt_q == 3'd4) begin
        cmd_valid_o = 1'b1;
        cmd_o.res.kind = KIND_HEADER;
        cmd_o.res.image_width = wid_q;
        cmd_o.res.image_height = hgt_q;
        col_d = '0;
        comp_d = '0;
        phase_d = (left_d != 0) ? PH_PIXELS : PH_DONE;
      end else begin
        phase_d = PH_MAXVAL;
      end
    end else if (take && phase_q != PH_DONE) begin
      if (in_data_i.end_of_file) begin
        cmd_valid_o = 1'b1;
        cmd_o.res.kind = KIND_ERROR;
        cmd_o.res.error_code = (phase_q <= PH_FORMAT) ? ERR_MAGIC : ERR_EOF;
        phase_d = PH_DONE;
      end else begin
        unique case (phase_q)
          PH_MAGIC: begin
            if (c == 8'h50) phase_d = PH_FORMAT;
            else begin
              cmd_valid_o = 1'b1;
              cmd_o.res.kind = KIND_ERROR;
              phase_d = PH_DONE;
            end
          end
          PH_FORMAT: begin
            if (c >= 8'h31 && c <= 8'h36) begin
              fmt_d = c[2:0];
              phase_d = PH_WIDTH;
            end else begin
              cmd_valid_o = 1'b1;
              cmd_o.res.kind = KIND_ERROR;
              phase_d = PH_DONE;
            end
          end
          PH_WIDTH: begin
            if (tok) begin
              wid_d = ({1'b0, tokv} > DimMax) ? DimMax[15:0] : tokv;
              phase_d = PH_HEIGHT;
            end
          end
          PH_HEIGHT: begin
            if (tok) begin
              hgt_d = ({1'b0, tokv} > DimMax) ? DimMax[15:0] : tokv;
              mul_d = 1'b1;
            end
          end
          PH_MAXVAL: begin
            if (tok) begin
              max_d = tokv;
              cmd_valid_o = 1'b1;
              if (tokv == 16'd0) begin
                cmd_o.res.kind = KIND_ERROR;
                cmd_o.res.error_code = ERR_MAXVAL;
                phase_d = PH_DONE;
              end else begin
                cmd_o.res.kind = KIND_HEADER;
                cmd_o.res.image_width = wid_q;
                cmd_o.res.image_height = hgt_q;
                col_d = '0;
                comp_d = '0;
                phase_d = (left_q != 0) ? PH_PIXELS : PH_DONE;
              end
            end
          end
          PH_PIXELS: begin
            if (fmt_q == 3'd4) begin
              cmd_valid_o = 1'b1;
              cmd_o.op = OP_BITS;
              cmd_o.value = {8'd0, c};
              if (left_q <= {28'd0, nbits}) begin
                cmd_o.bit_cnt = left_q[3:0];
                cmd_o.done_run = 1'b1;
                left_d = '0;
                phase_d = PH_DONE;
              end else begin
                cmd_o.bit_cnt = nbits;
                left_d = left_q - {28'd0, nbits};
              end
              col_d = ((col_q + {12'd0, nbits}) >= wid_q) ? 16'd0
                                                          : col_q + {12'd0, nbits};
            end else if (fmt_q >= 3'd5 || tok) begin
              cmd_o.op = OP_SAMPLE;
              cmd_o.value = (fmt_q >= 3'd5) ? {8'd0, c} : tokv;
              cmd_o.res.kind = KIND_PIXEL;
              cmd_valid_o = 1'b1;
              if (fmt_q == 3'd3 || fmt_q == 3'd6) begin
                cmd_o.res.last_in_run = (comp_q == 2'd2);
                comp_d = (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
              end
              if (fmt_q == 3'd1 || fmt_q == 3'd2 || fmt_q == 3'd5 || comp_q == 2'd2) begin
                left_d = left_q - 32'd1;
                if (left_q == 32'd1) begin
                  cmd_o.res.last_pixel = 1'b1;
                  phase_d = PH_DONE;
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAGIC;
      fmt_q <= '0; wid_q <= '0; hgt_q <= '0; max_q <= '0; acc_q <= '0;
      cmt_q <= 1'b0; dig_q <= 1'b0; left_q <= '0; col_q <= '0; comp_q <= '0;
      mul_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      fmt_q <= fmt_d; wid_q <= wid_d; hgt_q <= hgt_d; max_q <= max_d;
      left_q <= left_d; col_q <= col_d; comp_q <= comp_d;
      mul_q <= mul_d;
      if (take && !in_data_i.end_of_file &&
          (phase_q == PH_WIDTH || phase_q == PH_HEIGHT || phase_q == PH_MAXVAL ||
           (phase_q == PH_PIXELS && fmt_q <= 3'd3))) begin
        acc_q <= acc_d; cmt_q <= cmt_d; dig_q <= dig_d;
      end
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/pnm_queue.sv
`default_nettype none
module pnm_queue #(
  parameter int Depth = 2
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push_i,
  input  pnm_pkg::pnm_cmd_t push_data_i,
  output logic              full_o,
  output logic              valid_o,
  input  wire               pop_i,
  output pnm_pkg::pnm_cmd_t data_o
);
  import pnm_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  pnm_cmd_t          mem_q [Depth];
  logic [AW-1:0]     wr_q, rd_q;
  logic [AW:0]       cnt_q;

  assign full_o = (cnt_q == (AW+1)'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i) rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/pnm_back.sv
`default_nettype none
module pnm_back (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cmd_valid_i,
  input  pnm_pkg::pnm_cmd_t cmd_i,
  output logic              cmd_pop_o,
  input  wire [15:0]        maxval_i,
  input  wire [2:0]         format_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output pnm_pkg::pnm_out_t out_data_o
);
  import pnm_pkg::*;

  pnm_back_e   st_q, st_d;
  pnm_cmd_t    cmd_q, cmd_d;
  // restoring divider
  logic [24:0] rem_q, rem_d;
  logic [24:0] quo_q, quo_d;
  logic [4:0]  it_q, it_d;
  logic [7:0]  red_q, red_d, grn_q, grn_d;
  logic [1:0]  comp_q, comp_d;
  logic [3:0]  bit_q, bit_d;
  logic        ov_q, ov_d;
  pnm_out_t    out_q, out_d;

  logic [24:0] num, trial;
  logic [7:0]  s, g;
  logic        emit;
  pnm_out_t    res;

  assign out_valid_o = ov_q;
  assign out_data_o = out_q;
  assign emit = !ov_q || !out_stall_i;

  always_comb begin
    num = {1'b0, cmd_i.value, 8'd0} - {9'd0, cmd_i.value} + {10'd0, maxval_i[15:1]};
    trial = {rem_q[23:0], quo_q[24]};
    s = (quo_q > 25'd255) ? 8'hff : quo_q[7:0];
  end

  always_comb begin
    st_d = st_q; cmd_d = cmd_q; rem_d = rem_q; quo_d = quo_q; it_d = it_q;
    red_d = red_q; grn_d = grn_q; comp_d = comp_q; bit_d = bit_q;
    ov_d = ov_q && out_stall_i;
    out_d = out_q;
    cmd_pop_o = 1'b0;
    res = cmd_q.res;
    g = 8'd0;
    unique case (st_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d = cmd_i;
          unique case (cmd_i.op)
            OP_SAMPLE: begin
              if (format_i == 3'd1) begin
                rem_d = '0;
                quo_d = (cmd_i.value == 16'd0) ? 25'd255 : 25'd0;
                st_d = BK_OUT;
              end else begin
                rem_d = '0; quo_d = num; it_d = 5'd0; st_d = BK_DIV;
              end
            end
            OP_BITS: begin
              bit_d = '0;
              st_d = (cmd_i.bit_cnt == 4'd0) ? BK_IDLE : BK_BITS;
            end
            default: st_d = BK_OUT;
          endcase
        end
      end
      BK_DIV: begin
        if (trial >= {9'd0, maxval_i}) begin
          rem_d = trial - {9'd0, maxval_i};
          quo_d = {quo_q[23:0], 1'b1};
        end else begin
          rem_d = trial;
          quo_d = {quo_q[23:0], 1'b0};
        end
        it_d = it_q + 5'd1;
        if (it_q == 5'd24) st_d = BK_OUT;
      end
      BK_OUT: begin
        if (emit) begin
          st_d = BK_IDLE;
          if (cmd_q.op == OP_SAMPLE) begin
            if (format_i == 3'd3 || format_i == 3'd6) begin
              comp_d = (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
              if (comp_q == 2'd0) red_d = s;
              if (comp_q == 2'd1) grn_d = s;
              res.red = red_q; res.green = grn_q; res.blue = s;
              if (comp_q == 2'd2) begin
                ov_d = 1'b1; out_d = res;
              end
            end else begin
              res.red = s; res.green = s; res.blue = s;
              ov_d = 1'b1; out_d = res;
            end
          end else begin
            ov_d = 1'b1; out_d = res;
          end
        end
      end
      BK_BITS: begin
        if (emit) begin
          g = cmd_q.value[3'd7 - bit_q[2:0]] ? 8'd0 : 8'hff;
          res = '0;
          res.kind = KIND_PIXEL;
          res.red = g; res.green = g; res.blue = g;
          res.last_in_run = (bit_q + 4'd1 == cmd_q.bit_cnt);
          res.last_pixel = res.last_in_run && cmd_q.done_run;
          ov_d = 1'b1; out_d = res;
          bit_d = bit_q + 4'd1;
          if (res.last_in_run) st_d = BK_IDLE;
        end
      end
      default: st_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; rem_q <= rem_d; quo_q <= quo_d; out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE; it_q <= '0; red_q <= '0; grn_q <= '0;
      comp_q <= '0; bit_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; it_q <= it_d; red_q <= red_d; grn_q <= grn_d;
      comp_q <= comp_d; bit_q <= bit_d; ov_q <= ov_d;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/pnm_stream_to_rgb_decoder.sv
`default_nettype none
// Channel  Dir  Payload     Handshake
// in       in   pnm_in_t    in_valid_i / in_stall_o
// out      out  pnm_out_t   out_valid_o / out_stall_i
//
// The input stalls while the two-entry queue is full and in the product
// cycle, in which the front end forms width*height after the height token.
// Each PGM/PPM sample is scaled in the back end's restoring divider (25
// quotient bits, one per cycle). Binary PBM bytes give one pixel per cycle
// while the output is not stalled. Reset clears all control state.
module pnm_stream_to_rgb_decoder #(
  parameter int DIM_BITS = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  pnm_pkg::pnm_in_t  in_data_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output pnm_pkg::pnm_out_t out_data_o
);
  import pnm_pkg::*;

  logic        f_valid, q_full, q_valid, q_pop;
  pnm_cmd_t    f_cmd, q_cmd;
  logic [15:0] maxval;
  logic [2:0]  fmt;

  pnm_front #(.DimBits(DIM_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .cmd_valid_o(f_valid), .cmd_full_i(q_full), .cmd_o(f_cmd),
    .maxval_o(maxval), .format_o(fmt)
  );

  pnm_queue #(.Depth(2)) u_queue (
    .clk_i, .rst_ni, .push_i(f_valid), .push_data_i(f_cmd), .full_o(q_full),
    .valid_o(q_valid), .pop_i(q_pop), .data_o(q_cmd)
  );

  pnm_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(q_valid), .cmd_i(q_cmd), .cmd_pop_o(q_pop),
    .maxval_i(maxval), .format_i(fmt),
    .out_valid_o, .out_stall_i, .out_data_o
  );
endmodule
`default_nettype wire
